/* src/dip_pkg.sv */
// Package for the saturating decimal integer parser.
// Holds the token state type, compare and status codes, and the limit digit table.
// No dependencies; used by dip_finish and decimal_int_parser_saturating.
package dip_pkg;

  localparam int unsigned MaxDigits = 10;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  localparam logic [31:0] IntMax = 32'h7FFF_FFFF;
  localparam logic [31:0] IntMin = 32'h8000_0000;

  // Result of comparing the significant digits against the limit.
  typedef enum logic [1:0] {
    CmpEq = 2'd0,
    CmpLt = 2'd1,
    CmpGt = 2'd2
  } cmp_e;

  // Status code carried with each result.
  typedef enum logic [1:0] {
    StOk  = 2'd0,
    StNan = 2'd1,
    StSat = 2'd2
  } status_e;

  // Per-token accumulated state.
  typedef struct packed {
    logic        negative;
    logic [3:0]  digit_cnt;
    cmp_e        cmp;
    logic        bad;
    logic        ovf;
    logic [31:0] magnitude;
  } token_t;

  // Digit of the limit at a given position; the last digit is 8 for negative tokens.
  function automatic logic [3:0] limit_digit(logic [3:0] pos, logic negative);
    logic [3:0] d;
    case (pos)
      4'd0:    d = 4'd2;
      4'd1:    d = 4'd1;
      4'd2:    d = 4'd4;
      4'd3:    d = 4'd7;
      4'd4:    d = 4'd4;
      4'd5:    d = 4'd8;
      4'd6:    d = 4'd3;
      4'd7:    d = 4'd6;
      4'd8:    d = 4'd4;
      4'd9:    d = negative ? 4'd8 : 4'd7;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

/* src/dip_finish.sv */
// Result formatting for the decimal integer parser: saturation, negation and status.
// Purely combinational; depends on dip_pkg.
module dip_finish (
  input  dip_pkg::token_t  tok_i,
  output logic [31:0]      value_o,
  output dip_pkg::status_e status_o
);

  logic sat;

  // Saturate on an eleventh digit, or on ten digits above the limit.
  assign sat = tok_i.ovf ||
               (!tok_i.bad && (tok_i.cmp == dip_pkg::CmpGt) &&
                (tok_i.digit_cnt == 4'(dip_pkg::MaxDigits)));

  always_comb begin
    if (sat) begin
      value_o  = tok_i.negative ? dip_pkg::IntMin : dip_pkg::IntMax;
      status_o = dip_pkg::StSat;
    end else if (tok_i.bad) begin
      value_o  = 32'd0;
      status_o = dip_pkg::StNan;
    end else begin
      value_o  = tok_i.negative ? (32'd0 - tok_i.magnitude) : tok_i.magnitude;
      status_o = dip_pkg::StOk;
    end
  end

endmodule

/* src/decimal_int_parser_saturating.sv */
// Saturating ASCII decimal to signed 32-bit integer parser, one character per transfer.
// A result is registered on the transfer of its ending delimiter and is valid in the next cycle.
// Throughput: one character per cycle; the output register lets the next character
// be taken while a result is being taken, and input stalls only while a held result is not taken.
// Reset: asynchronous active low, clears the token state and the output valid.
// Depends on dip_pkg and dip_finish.
module decimal_int_parser_saturating (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         char_in_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);

  typedef enum logic [2:0] {
    PhSkip = 3'd0,
    PhSign = 3'd1,
    PhZero = 3'd2,
    PhBody = 3'd3
  } phase_e;

  phase_e            phase_q, phase_d;
  dip_pkg::token_t   tok_q, tok_d, fin_tok;
  logic              emit;
  logic              in_xfer;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       value_q, fin_value;
  dip_pkg::status_e  status_q, fin_status;

  logic              is_delim, is_digit, is_zero;
  logic [3:0]        digit;
  logic [3:0]        lim;
  logic [31:0]       mag_next;

  // Character classes.
  assign is_delim = (char_in_i == dip_pkg::ChSpace) || (char_in_i == dip_pkg::ChNewline);
  assign is_digit = (char_in_i >= dip_pkg::ChZero) && (char_in_i <= dip_pkg::ChNine);
  assign is_zero  = (char_in_i == dip_pkg::ChZero);
  assign digit    = 4'(char_in_i - dip_pkg::ChZero);

  // Digit accumulation: magnitude * 10 + digit, modulo 2^32.
  assign lim      = dip_pkg::limit_digit(tok_q.digit_cnt, tok_q.negative);
  assign mag_next = {tok_q.magnitude[28:0], 3'b000} + {tok_q.magnitude[30:0], 1'b0} +
                    {28'd0, digit};

  // Handshake: accept unless a held result is not being taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Next token state for one character.
  always_comb begin
    phase_d = phase_q;
    tok_d   = tok_q;
    fin_tok = tok_q;
    emit    = 1'b0;

    case (phase_q)
      PhSign: begin
        if (is_delim) begin
          fin_tok.bad = 1'b1;
          emit        = 1'b1;
        end else if (!is_digit) begin
          tok_d.bad = 1'b1;
          phase_d   = PhBody;
        end else if (is_zero) begin
          phase_d = PhZero;
        end else begin
          phase_d = PhBody;
        end
      end
      PhZero: begin
        if (!is_zero) begin
          phase_d = PhBody;
          if (is_delim) begin
            emit = 1'b1;
          end
        end
      end
      PhBody: begin
        if (is_delim) begin
          emit = 1'b1;
        end
      end
      default: begin
        phase_d = PhSkip;
        if (is_delim) begin
          phase_d = PhSkip;
        end else if ((char_in_i == dip_pkg::ChPlus) || (char_in_i == dip_pkg::ChMinus)) begin
          tok_d.negative = (char_in_i == dip_pkg::ChMinus);
          phase_d        = PhSign;
        end else if (is_zero) begin
          phase_d = PhZero;
        end else begin
          phase_d = PhBody;
        end
      end
    endcase

    // Body handling once the character reached the digit body.
    if ((phase_d == PhBody) && !emit && !(phase_q == PhSign && !is_digit)) begin
      if (tok_q.bad || tok_q.ovf) begin
        tok_d.bad = tok_q.bad;
      end else if (!is_digit) begin
        tok_d.bad = 1'b1;
      end else if (tok_q.digit_cnt >= 4'(dip_pkg::MaxDigits)) begin
        tok_d.ovf = 1'b1;
      end else begin
        if (tok_q.cmp == dip_pkg::CmpEq) begin
          if (digit > lim) begin
            tok_d.cmp = dip_pkg::CmpGt;
          end else if (digit < lim) begin
            tok_d.cmp = dip_pkg::CmpLt;
          end
        end
        tok_d.magnitude = mag_next;
        tok_d.digit_cnt = tok_q.digit_cnt + 4'd1;
      end
    end

    // A delimiter that ends a token clears it.
    if (emit) begin
      phase_d = PhSkip;
      tok_d   = '{negative: 1'b0, digit_cnt: 4'd0, cmp: dip_pkg::CmpEq,
                  bad: 1'b0, ovf: 1'b0, magnitude: 32'd0};
    end
  end

  dip_finish u_finish (
    .tok_i    (fin_tok),
    .value_o  (fin_value),
    .status_o (fin_status)
  );

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_xfer && emit) begin
      out_valid_d = 1'b1;
    end
  end

  // Token state, output valid and result payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSkip;
      tok_q       <= '{negative: 1'b0, digit_cnt: 4'd0, cmp: dip_pkg::CmpEq,
                       bad: 1'b0, ovf: 1'b0, magnitude: 32'd0};
      out_valid_q <= 1'b0;
      value_q     <= 32'd0;
      status_q    <= dip_pkg::StOk;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        phase_q <= phase_d;
        tok_q   <= tok_d;
      end
      if (in_xfer && emit) begin
        value_q  <= fin_value;
        status_q <= fin_status;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  // Checks on the parser's own logic.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_q.digit_cnt <= 4'(dip_pkg::MaxDigits))
    else $error("digit count beyond ten");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 2'd3))
    else $error("undefined status code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == dip_pkg::StNan)) |-> (value_o == 32'd0))
    else $error("not-a-number result with nonzero value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == dip_pkg::StSat)) |->
      ((value_o == dip_pkg::IntMax) || (value_o == dip_pkg::IntMin)))
    else $error("saturated result not at a limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && emit) |=> (phase_q == PhSkip) && (tok_q.digit_cnt == 4'd0))
    else $error("token state not cleared after a result");

endmodule
